### hw/rtl/b64enc_pkg.sv
// ============================================================================
// b64enc_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ============================================================================
package b64enc_pkg;

    // Character codes
    localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
    localparam logic [5:0] SEXTET_MAX = 6'd63;

    // Group queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One 24-bit group ready to be turned into four characters
    typedef struct packed {
        logic [23:0] word;   // first byte in bits 23..16
        logic [1:0]  pads;   // number of trailing '=' characters
        logic        last;   // group closes the message
    } t_group;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

### hw/rtl/b64enc_ifs.sv
// ============================================================================
// b64enc_ifs
// Valid/ready channels: raw byte input and encoded character output.
// ============================================================================

// Raw byte channel
interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Encoded character channel
interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

### hw/rtl/b64enc_front.sv
// ============================================================================
// b64enc_front
// Accepts bytes, collects groups of three and pushes finished groups.
// ============================================================================
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64enc_byte_if.sink   i_byte,
    output logic          o_push_valid,
    output t_group        o_push_data,
    input  logic          i_push_ready
);

    logic [15:0] r_held, n_held;
    logic [1:0]  r_count, n_count;
    logic        accept;
    logic        closes;

    // Bytes are taken only when a group can always be pushed
    assign i_byte.ready = i_push_ready;
    assign accept       = i_byte.valid && i_push_ready;

    // Classify the byte against the held group
    always_comb begin
        n_held            = r_held;
        n_count           = r_count;
        closes            = 1'b0;
        o_push_data.word  = 24'h0;
        o_push_data.pads  = 2'd0;
        o_push_data.last  = i_byte.final_byte;
        case (r_count)
            2'd1: begin
                o_push_data.word = {r_held[15:8], i_byte.data_byte, 8'h00};
                o_push_data.pads = 2'd1;
                closes           = i_byte.final_byte;
                n_held           = {r_held[15:8], i_byte.data_byte};
                n_count          = 2'd2;
            end
            2'd2: begin
                o_push_data.word = {r_held, i_byte.data_byte};
                o_push_data.pads = 2'd0;
                closes           = 1'b1;
            end
            default: begin
                // empty group (a count of three is treated the same)
                o_push_data.word = {i_byte.data_byte, 16'h0000};
                o_push_data.pads = 2'd2;
                closes           = i_byte.final_byte;
                n_held           = {i_byte.data_byte, 8'h00};
                n_count          = 2'd1;
            end
        endcase
        if (closes) begin
            n_held  = 16'h0000;
            n_count = 2'd0;
        end
    end

    assign o_push_valid = accept && closes;

    // Group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 16'h0000;
            r_count <= 2'd0;
        end else if (accept) begin
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    // a full group is always flushed, so the count never reaches three
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("front group count reached three");
`endif

endmodule

### hw/rtl/b64enc_queue.sv
// ============================================================================
// b64enc_queue
// Short group queue decoupling the front from the character back end.
// ============================================================================
module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    input  t_group  i_push_data,
    output logic    o_push_ready,
    output logic    o_pop_valid,
    output t_group  o_pop_data,
    input  logic    i_pop_ready
);

    t_group            r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count above depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with fill count");
`endif

endmodule

### hw/rtl/b64enc_back.sv
// ============================================================================
// b64enc_back
// Takes queued groups; four characters each, one per cycle unless stalled.
// ============================================================================
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  t_group         i_pop_data,
    output logic           o_pop_ready,
    b64enc_char_if.source  o_char
);

    t_group      r_grp;
    logic        r_busy;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;
    logic        advance;
    logic        load;
    logic [5:0]  sextet;
    logic [2:0]  pad_sum;
    logic [7:0]  n_char;

    // Output register moves when empty or taken
    assign advance     = !r_out_valid || o_char.ready;
    assign load        = i_pop_valid && (!r_busy || (advance && r_idx == 2'd3));
    assign o_pop_ready = load;

    // Character for the current position
    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.word[23:18];
            2'd1:    sextet = r_grp.word[17:12];
            2'd2:    sextet = r_grp.word[11:6];
            default: sextet = r_grp.word[5:0] & SEXTET_MAX;
        endcase
        pad_sum = {1'b0, r_idx} + {1'b0, r_grp.pads};
        n_char  = (pad_sum > 3'd3) ? PAD_CHAR : sextet_to_char(sextet);
    end

    // Group register and position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (advance && r_busy) begin
            r_idx <= r_idx + 2'd1;
            if (r_idx == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_grp <= i_pop_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_out_char <= n_char;
            r_out_last <= r_grp.last && (r_idx == 2'd3);
        end
    end

    assign o_char.valid     = r_out_valid;
    assign o_char.out_char  = r_out_char;
    assign o_char.last_char = r_out_last;

`ifndef SYNTHESIS
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == 2'd0)
        else $error("position counter moved without a group");
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_idx) == 2'd3 && r_out_valid)
        else $error("group dropped before its fourth character");
`endif

endmodule

### hw/rtl/base64_stream_encoder_top.sv
// ============================================================================
// base64_stream_encoder_top
// Base64 encoder over a byte stream, standard alphabet with '=' padding.
// ============================================================================
// Usage:
//   i_byte (sink): one raw byte per transfer; final_byte marks the last byte
//   of a message. o_char (source): one ASCII character per transfer;
//   last_char marks the final character of the message.
//   Every third byte, or a final byte, closes a group of four characters;
//   a short final group gets one or two '=' characters. A message with no
//   bytes gives no characters.
// Path: the group of a closing byte is written into the queue, loaded into
//   the back end group register, then its first character is registered.
// Throughput: one byte per cycle while the two-entry group queue has room;
//   the character side produces one character per cycle from the back end
//   group register while the receiver is ready, and sets the sustained rate.
// Reset (synchronous, active low): held bytes, queue and output are
//   cleared; no character is pending afterwards.
// Receiver stall: the output register holds its character, the back end
//   stops, the queue fills, and then i_byte.ready drops.
// ============================================================================
module base64_stream_encoder_top
    import b64enc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    b64enc_byte_if.sink    i_byte,
    b64enc_char_if.source  o_char
);

    logic   push_valid, push_ready;
    t_group push_data;
    logic   pop_valid, pop_ready;
    t_group pop_data;

    b64enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    b64enc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_char      (o_char)
    );

endmodule
